// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the deque block.
// Clocked on clock, disabled while reset is high; empty when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPL(label, pre, post, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== hdl/adq_pkg.sv =====
// Package for the array deque: depth, index width, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps

package adq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      KIND_PUSH_BACK  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type LAST_IDX = idx_type'(DEPTH - 1);

endpackage

// ===== hdl/adq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module adq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/array_double_ended_queue.sv =====
// Array deque: push/pop at either end of a linear, non-wrapping slot array.
// Response: pushes and refused pops show their word in the cycle after accept,
// successful pops pass the slot RAM read register and then the output register.
// Throughput: 1 word per cycle while rsp_ready is high, except a successful pop
// holds req_ready low in ST_READ while the RAM read port returns the slot.
// Reset (synchronous): queue empty, indices zero; slot contents are kept.
`timescale 1ns / 1ps

module array_double_ended_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic signed [adq_pkg::DATA_W-1:0] req_push_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [adq_pkg::DATA_W-1:0] rsp_pop_value,
   output logic [1:0]                    rsp_status
);

   import adq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   idx_type     head_ff, head_in;
   idx_type     tail_ff, tail_in;
   logic        is_empty_ff, is_empty_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] pop_value_ff, pop_value_in;
   status_type  status_ff, status_in;

   logic        accept;
   logic        pop_ok;
   status_type  op_status;
   logic        wr_en;
   idx_type     wr_addr;
   logic        rd_en;
   idx_type     rd_addr;
   logic [DATA_W-1:0] rd_data;
   kind_type    kind;

   assign kind      = kind_type'(req_kind);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // decode the request against the current indices
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      is_empty_in = is_empty_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      rd_en       = 1'b0;
      rd_addr     = head_ff;
      pop_ok      = 1'b0;
      op_status   = STATUS_OK;
      if (accept) begin
         unique case (kind)
            KIND_PUSH_BACK: begin
               if (is_empty_ff) begin
                  wr_en       = 1'b1;
                  head_in     = '0;
                  tail_in     = '0;
                  is_empty_in = 1'b0;
               end else if (tail_ff == LAST_IDX) begin
                  op_status = STATUS_FULL;
               end else begin
                  tail_in = tail_ff + idx_type'(1);
                  wr_en   = 1'b1;
                  wr_addr = tail_ff + idx_type'(1);
               end
            end
            KIND_PUSH_FRONT: begin
               if (is_empty_ff) begin
                  wr_en       = 1'b1;
                  head_in     = '0;
                  tail_in     = '0;
                  is_empty_in = 1'b0;
               end else if (head_ff == '0) begin
                  op_status = STATUS_FULL;
               end else begin
                  head_in = head_ff - idx_type'(1);
                  wr_en   = 1'b1;
                  wr_addr = head_ff - idx_type'(1);
               end
            end
            KIND_POP_FRONT: begin
               if (is_empty_ff) begin
                  op_status = STATUS_EMPTY;
               end else begin
                  pop_ok  = 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = head_ff;
                  if (head_ff == tail_ff) begin
                     is_empty_in = 1'b1;
                     head_in     = '0;
                     tail_in     = '0;
                  end else begin
                     head_in = head_ff + idx_type'(1);
                  end
               end
            end
            KIND_POP_BACK: begin
               if (is_empty_ff) begin
                  op_status = STATUS_EMPTY;
               end else begin
                  pop_ok  = 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = tail_ff;
                  if (head_ff == tail_ff) begin
                     is_empty_in = 1'b1;
                     head_in     = '0;
                     tail_in     = '0;
                  end else begin
                     tail_in = tail_ff - idx_type'(1);
                  end
               end
            end
         endcase
      end
   end

   // sequencer and output word register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      pop_value_in = pop_value_ff;
      status_in    = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && pop_ok) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      priority if (state_ff == ST_READ) begin
         // slot data is back from the RAM
         rsp_valid_in = 1'b1;
         pop_value_in = rd_data;
         status_in    = STATUS_OK;
      end else if (accept && !pop_ok) begin
         rsp_valid_in = 1'b1;
         pop_value_in = '0;
         status_in    = op_status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         is_empty_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         is_empty_ff  <= is_empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pop_value_ff <= pop_value_in;
      status_ff    <= status_in;
   end

   adq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(req_push_value)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = $signed(pop_value_ff);
   assign rsp_status    = status_ff;

`include "assert_macros.svh"

   `ASSERT_IMPL(a_empty_idx_zero, is_empty_ff, (head_ff == '0) && (tail_ff == '0), "empty queue with nonzero index")
   `ASSERT_IMPL(a_head_le_tail, !is_empty_ff, head_ff <= tail_ff, "head past tail")
   `ASSERT_IMPL(a_no_accept_in_read, state_ff == ST_READ, !req_ready, "request taken during slot read")
   `ASSERT_NEXT(a_read_fills_out, state_ff == ST_READ, rsp_valid_ff && (status_ff == STATUS_OK), "pop word not loaded after read")
   `ASSERT_IMPL(a_no_wr_on_pop, rd_en, !wr_en, "slot read and write on one request")

endmodule
